[rtl/core/nbbl_pkg.sv]
// Shared types, constants and log2 helper functions for the naive Bayes labeller.
package nbbl_pkg;

    localparam int FIFO_DEPTH = 32;
    localparam int FIFO_PTR_W = 5;
    localparam int FIFO_CNT_W = 6;

    localparam logic signed [31:0] LOG_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] LOG_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic               last;
        logic               has_word;
        logic               good_zero;
        logic               bad_zero;
        logic signed [31:0] good_log;
        logic signed [31:0] bad_log;
    } nbbl_tok_t;

    typedef struct packed {
        logic [4:0]  p;
        logic [31:0] y;
    } nbbl_norm_t;

    typedef struct packed {
        logic        frac_bit;
        logic [31:0] y;
    } nbbl_sq_t;

    // Top set bit and mantissa shifted up to bit 31.
    function automatic nbbl_norm_t nbbl_norm(input logic [31:0] x);
        nbbl_norm_t r;
        r.p = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (x[i])
            begin
                r.p = 5'(i);
            end
        end
        r.y = x << (5'd31 - r.p);
        return r;
    endfunction

    // One fraction bit: square, renormalize.
    function automatic nbbl_sq_t nbbl_sq_step(input logic [31:0] y);
        logic [63:0] sq;
        logic [32:0] t;
        nbbl_sq_t    r;
        sq = 64'(y) * 64'(y);
        t  = sq[63:31];
        r.frac_bit = t[32];
        r.y = t[32] ? t[32:1] : t[31:0];
        return r;
    endfunction

    // (p - 32) * 2^f + frac; p - 32 in six bits is {1, p}.
    function automatic logic signed [31:0] nbbl_make_log(input logic [4:0] p,
                                                         input logic [31:0] frac,
                                                         input int f);
        logic signed [31:0] e;
        e = $signed({{27{1'b1}}, p});
        return (e <<< f) | $signed(frac);
    endfunction

endpackage

[rtl/core/naive_bayes_binary_labeller.sv]
// Naive Bayes binary labeller top level.
// Throughput: one item per cycle while queue credits remain; at most 32 items are in flight.
// A label passes the log2 pipeline, queue, decision and output registers after its last item.
// The log2 pipeline has one squaring stage per fraction bit; prior logs are computed iteratively.
// Reset (rst_n low, async): prior is one half, counts and sums clear, no items in flight.
module naive_bayes_binary_labeller
    import nbbl_pkg::*;
#(
    parameter int MAX_WORDS     = 256,
    parameter int LOG_FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] good_likelihood,
    input  logic [31:0] bad_likelihood,
    input  logic        has_word,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  label
);

    logic               pop;
    logic               tok_valid;
    nbbl_tok_t          tok;
    logic               head_valid;
    nbbl_tok_t          head_tok;
    logic signed [31:0] prior_log_good;
    logic signed [31:0] prior_log_bad;

    nbbl_front #(
        .LOG_FRAC_BITS (LOG_FRAC_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .good_likelihood (good_likelihood),
        .bad_likelihood  (bad_likelihood),
        .has_word        (has_word),
        .last            (last),
        .pop             (pop),
        .tok_valid       (tok_valid),
        .tok             (tok)
    );

    nbbl_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (tok_valid),
        .push_tok   (tok),
        .pop        (pop),
        .head_valid (head_valid),
        .head_tok   (head_tok)
    );

    nbbl_prior_log #(
        .LOG_FRAC_BITS (LOG_FRAC_BITS)
    ) u_prior_log (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .prior_log_good (prior_log_good),
        .prior_log_bad  (prior_log_bad)
    );

    nbbl_back #(
        .MAX_WORDS (MAX_WORDS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head_tok       (head_tok),
        .pop            (pop),
        .prior_log_good (prior_log_good),
        .prior_log_bad  (prior_log_bad),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .label          (label)
    );

endmodule

[rtl/core/nbbl_log_pipe.sv]
// Pipelined fixed-point log2 of both likelihoods, one fraction bit per stage.
module nbbl_log_pipe
    import nbbl_pkg::*;
#(
    parameter int LOG_FRAC_BITS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [31:0]      good_likelihood,
    input  logic [31:0]      bad_likelihood,
    input  logic             has_word,
    input  logic             last,
    output logic             tok_valid,
    output nbbl_tok_t        tok
);

    localparam int F = LOG_FRAC_BITS;

    typedef struct packed {
        logic [31:0]  gy;
        logic [31:0]  by;
        logic [4:0]   gp;
        logic [4:0]   bp;
        logic [F-1:0] gf;
        logic [F-1:0] bf;
        logic         gz;
        logic         bz;
        logic         hw;
        logic         last;
    } stage_t;

    stage_t     stage_reg [0:F];
    logic       valid_reg [0:F];
    nbbl_norm_t g_norm;
    nbbl_norm_t b_norm;

    always_comb
    begin
        g_norm = nbbl_norm(good_likelihood);
        b_norm = nbbl_norm(bad_likelihood);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg[0].gy   <= g_norm.y;
        stage_reg[0].by   <= b_norm.y;
        stage_reg[0].gp   <= g_norm.p;
        stage_reg[0].bp   <= b_norm.p;
        stage_reg[0].gf   <= '0;
        stage_reg[0].bf   <= '0;
        stage_reg[0].gz   <= (good_likelihood == 32'd0);
        stage_reg[0].bz   <= (bad_likelihood == 32'd0);
        stage_reg[0].hw   <= has_word;
        stage_reg[0].last <= last;
    end

    for (genvar k = 1; k <= F; k++)
    begin : g_stage
        nbbl_sq_t g_sq;
        nbbl_sq_t b_sq;

        always_comb
        begin
            g_sq = nbbl_sq_step(stage_reg[k-1].gy);
            b_sq = nbbl_sq_step(stage_reg[k-1].by);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            stage_reg[k].gy   <= g_sq.y;
            stage_reg[k].by   <= b_sq.y;
            stage_reg[k].gp   <= stage_reg[k-1].gp;
            stage_reg[k].bp   <= stage_reg[k-1].bp;
            stage_reg[k].gf   <= {stage_reg[k-1].gf[F-2:0], g_sq.frac_bit};
            stage_reg[k].bf   <= {stage_reg[k-1].bf[F-2:0], b_sq.frac_bit};
            stage_reg[k].gz   <= stage_reg[k-1].gz;
            stage_reg[k].bz   <= stage_reg[k-1].bz;
            stage_reg[k].hw   <= stage_reg[k-1].hw;
            stage_reg[k].last <= stage_reg[k-1].last;
        end
    end

    always_comb
    begin
        tok_valid     = valid_reg[F];
        tok.last      = stage_reg[F].last;
        tok.has_word  = stage_reg[F].hw;
        tok.good_zero = stage_reg[F].gz;
        tok.bad_zero  = stage_reg[F].bz;
        tok.good_log  = nbbl_make_log(stage_reg[F].gp, 32'(stage_reg[F].gf), F);
        tok.bad_log   = nbbl_make_log(stage_reg[F].bp, 32'(stage_reg[F].bf), F);
    end

endmodule

[rtl/core/nbbl_front.sv]
// Front end: input handshake, queue credit tracking and the log2 pipeline.
module nbbl_front
    import nbbl_pkg::*;
#(
    parameter int LOG_FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] good_likelihood,
    input  logic [31:0] bad_likelihood,
    input  logic        has_word,
    input  logic        last,
    input  logic        pop,
    output logic        tok_valid,
    output nbbl_tok_t   tok
);

    logic [FIFO_CNT_W-1:0] used_reg;
    logic [FIFO_CNT_W-1:0] used_next;
    logic                  accept;

    // Items in the pipeline plus items in the queue never exceed its depth.
    assign in_ready = (used_reg < FIFO_CNT_W'(FIFO_DEPTH));
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        used_next = used_reg + FIFO_CNT_W'(accept) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    nbbl_log_pipe #(
        .LOG_FRAC_BITS (LOG_FRAC_BITS)
    ) u_log_pipe (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (accept),
        .good_likelihood (good_likelihood),
        .bad_likelihood  (bad_likelihood),
        .has_word        (has_word),
        .last            (last),
        .tok_valid       (tok_valid),
        .tok             (tok)
    );

endmodule

[rtl/core/nbbl_fifo.sv]
// Queue of log2-converted items between the front end and the accumulator.
module nbbl_fifo
    import nbbl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  nbbl_tok_t push_tok,
    input  logic      pop,
    output logic      head_valid,
    output nbbl_tok_t head_tok
);

    nbbl_tok_t             entry_reg [0:FIFO_DEPTH-1];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;

    assign head_valid = (count_reg != '0);
    assign head_tok   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            count_reg <= count_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

[rtl/core/nbbl_prior_log.sv]
// Iterative log2 of both class priors, recomputed after each prior write.
module nbbl_prior_log
    import nbbl_pkg::*;
#(
    parameter int LOG_FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_wdata,
    output logic signed [31:0] prior_log_good,
    output logic signed [31:0] prior_log_bad
);

    localparam int F     = LOG_FRAC_BITS;
    localparam int CNT_W = $clog2(F);

    logic                     busy_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [31:0]              gy_reg;
    logic [31:0]              by_reg;
    logic [4:0]               gp_reg;
    logic [4:0]               bp_reg;
    logic [F-1:0]             gf_reg;
    logic [F-1:0]             bf_reg;
    logic                     g_zero_reg;
    logic                     b_one_reg;
    logic signed [31:0]       log_good_reg;
    logic signed [31:0]       log_bad_reg;
    logic [31:0]              bad_prior;
    nbbl_norm_t               g_norm;
    nbbl_norm_t               b_norm;
    nbbl_sq_t                 g_sq;
    nbbl_sq_t                 b_sq;
    logic [F-1:0]             gf_next;
    logic [F-1:0]             bf_next;

    assign prior_log_good = log_good_reg;
    assign prior_log_bad  = log_bad_reg;

    always_comb
    begin
        bad_prior = (~cfg_wdata) + 32'd1;
        g_norm    = nbbl_norm(cfg_wdata);
        b_norm    = nbbl_norm(bad_prior);
        g_sq      = nbbl_sq_step(gy_reg);
        b_sq      = nbbl_sq_step(by_reg);
        gf_next   = {gf_reg[F-2:0], g_sq.frac_bit};
        bf_next   = {bf_reg[F-2:0], b_sq.frac_bit};
    end

    // Reset prior is one half for both classes: log2 = -1.0.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            cnt_reg      <= '0;
            log_good_reg <= -(32'sd1 <<< F);
            log_bad_reg  <= -(32'sd1 <<< F);
        end
        else if (cfg_we)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(F - 1))
            begin
                busy_reg     <= 1'b0;
                log_good_reg <= g_zero_reg ? LOG_MIN : nbbl_make_log(gp_reg, 32'(gf_next), F);
                log_bad_reg  <= b_one_reg ? 32'sd0 : nbbl_make_log(bp_reg, 32'(bf_next), F);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cfg_we)
        begin
            gy_reg     <= g_norm.y;
            by_reg     <= b_norm.y;
            gp_reg     <= g_norm.p;
            bp_reg     <= b_norm.p;
            gf_reg     <= '0;
            bf_reg     <= '0;
            g_zero_reg <= (cfg_wdata == 32'd0);
            b_one_reg  <= (cfg_wdata == 32'd0);
        end
        else if (busy_reg)
        begin
            gy_reg <= g_sq.y;
            by_reg <= b_sq.y;
            gf_reg <= gf_next;
            bf_reg <= bf_next;
        end
    end

endmodule

[rtl/core/nbbl_back.sv]
// Back end: zero counts, saturating log sums, decision and output register.
module nbbl_back
    import nbbl_pkg::*;
#(
    parameter int MAX_WORDS = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  nbbl_tok_t          head_tok,
    output logic               pop,
    input  logic signed [31:0] prior_log_good,
    input  logic signed [31:0] prior_log_bad,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         label
);

    localparam int CNT_W = $clog2(MAX_WORDS + 1);

    localparam logic [1:0] LABEL_GOOD      = 2'd0;
    localparam logic [1:0] LABEL_BAD       = 2'd1;
    localparam logic [1:0] LABEL_UNDECIDED = 2'd2;

    logic [CNT_W-1:0]   gz_cnt_reg;
    logic [CNT_W-1:0]   bz_cnt_reg;
    logic signed [31:0] g_sum_reg;
    logic signed [31:0] b_sum_reg;
    logic [CNT_W-1:0]   gz_cnt_next;
    logic [CNT_W-1:0]   bz_cnt_next;
    logic signed [31:0] g_sum_next;
    logic signed [31:0] b_sum_next;

    logic               dec_valid_reg;
    logic [CNT_W-1:0]   dec_gz_reg;
    logic [CNT_W-1:0]   dec_bz_reg;
    logic signed [31:0] dec_gs_reg;
    logic signed [31:0] dec_bs_reg;
    logic               dec_move;

    logic               out_valid_reg;
    logic [1:0]         label_reg;
    logic [1:0]         label_next;
    logic signed [32:0] g_total;
    logic signed [32:0] b_total;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31])
        begin
            return s[32] ? LOG_MIN : LOG_MAX;
        end
        return s[31:0];
    endfunction

    assign out_valid = out_valid_reg;
    assign label     = label_reg;

    assign dec_move = dec_valid_reg && (!out_valid_reg || out_ready);
    assign pop      = head_valid && (!head_tok.last || !dec_valid_reg || dec_move);

    always_comb
    begin
        gz_cnt_next = gz_cnt_reg;
        bz_cnt_next = bz_cnt_reg;
        g_sum_next  = g_sum_reg;
        b_sum_next  = b_sum_reg;
        if (head_tok.has_word)
        begin
            if (head_tok.good_zero)
            begin
                if (gz_cnt_reg != CNT_W'(MAX_WORDS))
                begin
                    gz_cnt_next = gz_cnt_reg + CNT_W'(1);
                end
            end
            else
            begin
                g_sum_next = sat_add(g_sum_reg, head_tok.good_log);
            end
            if (head_tok.bad_zero)
            begin
                if (bz_cnt_reg != CNT_W'(MAX_WORDS))
                begin
                    bz_cnt_next = bz_cnt_reg + CNT_W'(1);
                end
            end
            else
            begin
                b_sum_next = sat_add(b_sum_reg, head_tok.bad_log);
            end
        end
    end

    always_comb
    begin
        g_total = {dec_gs_reg[31], dec_gs_reg} + {prior_log_good[31], prior_log_good};
        b_total = {dec_bs_reg[31], dec_bs_reg} + {prior_log_bad[31], prior_log_bad};
        if (dec_gz_reg > dec_bz_reg)
        begin
            label_next = LABEL_BAD;
        end
        else if (dec_gz_reg < dec_bz_reg)
        begin
            label_next = LABEL_GOOD;
        end
        else if (g_total > b_total)
        begin
            label_next = LABEL_GOOD;
        end
        else if (g_total < b_total)
        begin
            label_next = LABEL_BAD;
        end
        else
        begin
            label_next = LABEL_UNDECIDED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gz_cnt_reg    <= '0;
            bz_cnt_reg    <= '0;
            g_sum_reg     <= '0;
            b_sum_reg     <= '0;
            dec_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (head_tok.last)
                begin
                    gz_cnt_reg <= '0;
                    bz_cnt_reg <= '0;
                    g_sum_reg  <= '0;
                    b_sum_reg  <= '0;
                end
                else
                begin
                    gz_cnt_reg <= gz_cnt_next;
                    bz_cnt_reg <= bz_cnt_next;
                    g_sum_reg  <= g_sum_next;
                    b_sum_reg  <= b_sum_next;
                end
            end
            if (pop && head_tok.last)
            begin
                dec_valid_reg <= 1'b1;
            end
            else if (dec_move)
            begin
                dec_valid_reg <= 1'b0;
            end
            if (dec_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head_tok.last)
        begin
            dec_gz_reg <= gz_cnt_next;
            dec_bz_reg <= bz_cnt_next;
            dec_gs_reg <= g_sum_next;
            dec_bs_reg <= b_sum_next;
        end
        if (dec_move)
        begin
            label_reg <= label_next;
        end
    end

endmodule
